@@ src/cil_pkg.sv @@
// ----------------------------------------------------------------------------
// cil_pkg: shared types and constants
// Item formats, operation and status codes, and the per-cell command bundle
// for the compacting indexed list.
// ----------------------------------------------------------------------------
package cil_pkg;

  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 32;
  localparam int IDX_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [IDX_BITS-1:0]  pos_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_READ   = 2'd2,
    KIND_DELETE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  index;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [6:0]  entry_count;
    status_t     status;
  } rsp_t;

  // broadcast to every cell, flags already qualified
  typedef struct packed {
    logic  append;
    logic  write;
    logic  del;
    pos_t  index;
    cnt_t  count;
    word_t value;
  } cell_cmd_t;

endpackage

@@ src/cil_cell.sv @@
// ----------------------------------------------------------------------------
// cil_cell: one list position
// Holds one word; loads on append or overwrite, takes the upper neighbor's
// word on a delete at or below its position, and offers its word for reads.
// ----------------------------------------------------------------------------
module cil_cell (
  input  logic               clk,
  input  cil_pkg::pos_t      pos,
  input  cil_pkg::cell_cmd_t cmd,
  input  cil_pkg::word_t     upper,
  output cil_pkg::word_t     word,
  output cil_pkg::word_t     tap
);

  cil_pkg::word_t word_next;
  logic           at_index;
  logic           at_tail;

  assign at_index = (pos == cmd.index);
  assign at_tail  = (pos == cil_pkg::IDX_BITS'(cmd.count));
  assign tap      = at_index ? word : '0;

  always_comb begin
    word_next = word;
    if (cmd.append && at_tail) begin
      word_next = cmd.value;
    end else if (cmd.write && at_index) begin
      word_next = cmd.value;
    end else if (cmd.del && (pos >= cmd.index)) begin
      word_next = upper;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

@@ src/compacting_indexed_list.sv @@
// ----------------------------------------------------------------------------
// compacting_indexed_list: fixed-capacity ordered list of words
// Append, overwrite, read and delete with compaction over a row of cells.
// ----------------------------------------------------------------------------
//  channel  signals                 payload
//  req      req_valid / req_ready   req (kind, index, value)
//  rsp      rsp_valid / rsp_ready   rsp (read_data, entry_count, status)
//
//  one item per cycle unless a result is stalled; the result appears in the cycle after acceptance
//  a delete shifts every cell at or above the index in the same cycle
//  req_ready is low only while a result waits and rsp_ready is low
//  reset clears the count and the result valid flag; cell words are not reset
// ----------------------------------------------------------------------------
module compacting_indexed_list (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cil_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cil_pkg::rsp_t rsp
);

  cil_pkg::cnt_t      count;
  cil_pkg::cnt_t      count_next;
  cil_pkg::cell_cmd_t cmd;
  cil_pkg::rsp_t      rsp_next;
  cil_pkg::word_t     words [cil_pkg::DEPTH];
  cil_pkg::word_t     taps  [cil_pkg::DEPTH];
  cil_pkg::word_t     rd_word;
  logic               accept;
  logic               in_range;
  logic               full;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign full      = (count >= cil_pkg::CNT_BITS'(cil_pkg::DEPTH));
  assign in_range  = (cil_pkg::CNT_BITS'(req.index) < count);

  always_comb begin
    cmd.append = accept && (req.kind == cil_pkg::KIND_APPEND) && !full;
    cmd.write  = accept && (req.kind == cil_pkg::KIND_WRITE) && in_range;
    cmd.del    = accept && (req.kind == cil_pkg::KIND_DELETE) && in_range;
    cmd.index  = cil_pkg::IDX_BITS'(req.index);
    cmd.count  = count;
    cmd.value  = cil_pkg::WORD_BITS'(req.value);
  end

  for (genvar i = 0; i < cil_pkg::DEPTH; i++) begin : g_cell
    cil_pkg::word_t upper;
    if (i == cil_pkg::DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = words[i+1];
    end
    cil_cell u_cell (
      .clk   (clk),
      .pos   (cil_pkg::IDX_BITS'(i)),
      .cmd   (cmd),
      .upper (upper),
      .word  (words[i]),
      .tap   (taps[i])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < cil_pkg::DEPTH; i++) begin
      rd_word = rd_word | taps[i];
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.append) begin
      count_next = count + cil_pkg::CNT_BITS'(1);
    end else if (cmd.del) begin
      count_next = count - cil_pkg::CNT_BITS'(1);
    end
  end

  always_comb begin
    rsp_next.read_data   = 32'({cil_pkg::WORD_BITS{1'b1}});
    rsp_next.entry_count = 7'(count_next);
    rsp_next.status      = cil_pkg::ST_DONE;
    case (req.kind)
      cil_pkg::KIND_APPEND: begin
        if (full) begin
          rsp_next.status = cil_pkg::ST_FULL;
        end
      end
      cil_pkg::KIND_READ: begin
        if (in_range) begin
          rsp_next.read_data = 32'(rd_word);
        end else begin
          rsp_next.status = cil_pkg::ST_RANGE;
        end
      end
      default: begin
        if (!in_range) begin
          rsp_next.status = cil_pkg::ST_RANGE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

@@ src/cil_checker.sv @@
// ----------------------------------------------------------------------------
// cil_checker: port-level checks
// Watches the request and result channels of the compacting indexed list.
// ----------------------------------------------------------------------------
module cil_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input cil_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.entry_count <= 7'(cil_pkg::DEPTH))
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == cil_pkg::ST_FULL |->
      rsp.entry_count == 7'(cil_pkg::DEPTH))
    else $error("full status without a full list");

  a_range_ones: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == cil_pkg::ST_RANGE |->
      rsp.read_data == 32'({cil_pkg::WORD_BITS{1'b1}}))
    else $error("rejected item returned data");

  a_issue: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("accepted item gave no result");

endmodule

bind compacting_indexed_list cil_checker u_cil_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
